FILE: sv/dsfrs_pkg.sv
// ----------------------------------------------------------------------------
// dsfrs_pkg: shared types and constants
// Request codes, sequencer states, fixed values and the divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfrs_pkg;

    localparam int RATE_W  = 18;
    localparam int CLOCK_W = 22;
    localparam int STEP_W  = 24;

    localparam logic [3:0] REQ_DATA_WR     = 4'd0;
    localparam logic [3:0] REQ_CTRL_WR     = 4'd1;
    localparam logic [3:0] REQ_DIVISOR_WR  = 4'd2;
    localparam logic [3:0] REQ_LEVEL_WR    = 4'd3;
    localparam logic [3:0] REQ_CMD_RD      = 4'd4;
    localparam logic [3:0] REQ_STATUS_RD   = 4'd5;
    localparam logic [3:0] REQ_DIVISOR_RD  = 4'd6;
    localparam logic [3:0] REQ_PRESENCE_RD = 4'd7;
    localparam logic [3:0] REQ_JOYSTICK_RD = 4'd8;
    localparam logic [3:0] REQ_FRAMES      = 4'd9;

    localparam logic       REG_OUTPUT_RATE = 1'b0;
    localparam logic       REG_DAC_CLOCK   = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 22'd1000000;

    localparam logic [7:0] MIDLINE      = 8'd128;
    localparam logic [7:0] PRESENCE     = 8'hFF;
    localparam logic [7:0] DIV_MIN      = 8'd45;
    localparam logic [7:0] DIV_FALLBACK = 8'd125;
    localparam logic [STEP_W-1:0] STEP_MAX = 24'hFFFFFF;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DIV_CLOCK = 7'b0000010,
        S_DIV_RATE  = 7'b0000100,
        S_DIV_SPAN  = 7'b0001000,
        S_FRAME_RD  = 7'b0010000,
        S_FRAME_OUT = 7'b0100000,
        S_EMIT      = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/dac_sample_fifo_with_rate_stepper_core.sv
// ----------------------------------------------------------------------------
// dac_sample_fifo_with_rate_stepper_core: 8-bit DAC sample FIFO and stepper
// Register requests in on s_, result words out on m_, rates over APB.
// ----------------------------------------------------------------------------
// Usage:
//  Each s_ word is one register access or a frame request. Every request
//  gives one m_ word, except a frame request, which gives one word per
//  sample (1..MAX_FRAMES); m_last_of_run marks the final word.
//  Timing: a plain request passes through S_EMIT to the output register. A
//  divisor write runs two passes of the shared bit-serial divider, the DAC
//  clock by the divisor byte and then that quotient by the output rate; with
//  a zero output rate the second pass is skipped. A frame request reads the
//  memory in S_FRAME_RD and loads the output register in S_FRAME_OUT for
//  each sample. s_ready is low until the last word has been loaded into the
//  output register.
//  Reset: sequencer, FIFO and configuration state return to defaults and
//  the sample memory is swept to midline with s_ready low; a level write of
//  zero starts the same sweep. APB writes are taken at any time.
//  A stalled receiver holds m_ words in the output register and pauses
//  the sequencer; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_sample_fifo_with_rate_stepper_core #(
    parameter int FIFO_DEPTH         = 2048,
    parameter int FRAC_BITS          = 12,
    parameter int NEARLY_EMPTY_LEVEL = 128,
    parameter int MAX_FRAMES         = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_req_type,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [5:0]  s_frame_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic [7:0]       m_sample_out,
    output logic             m_last_of_run,
    output logic             m_irq_raise,
    output logic             m_irq_level
);

    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int PW    = AW + FRAC_BITS;
    localparam int PENDW = PW + 1;
    localparam int DW0   = dsfrs_pkg::CLOCK_W + FRAC_BITS;
    localparam int DW    = (DW0 > PENDW) ? DW0 : PENDW;
    localparam int CMPW  = (PENDW > dsfrs_pkg::STEP_W) ? PENDW : dsfrs_pkg::STEP_W;
    localparam int FCW   = $clog2(MAX_FRAMES + 1);

    localparam logic [PENDW-1:0] SPAN     = PENDW'(FIFO_DEPTH) << FRAC_BITS;
    localparam logic [PENDW-1:0] ONE_WORD = PENDW'(1) << FRAC_BITS;
    localparam logic [63:0] NE_THR   = 64'(NEARLY_EMPTY_LEVEL) << FRAC_BITS;
    localparam logic [63:0] FULL_THR = 64'(FIFO_DEPTH - 1) << FRAC_BITS;

    // configuration
    logic [dsfrs_pkg::RATE_W-1:0]  out_rate_reg;
    logic [dsfrs_pkg::CLOCK_W-1:0] dac_clock_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_rate_reg  <= dsfrs_pkg::RATE_RESET;
            dac_clock_reg <= dsfrs_pkg::CLOCK_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                dsfrs_pkg::REG_OUTPUT_RATE: out_rate_reg  <= pwdata[dsfrs_pkg::RATE_W-1:0];
                dsfrs_pkg::REG_DAC_CLOCK:   dac_clock_reg <= pwdata[dsfrs_pkg::CLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dsfrs_pkg::REG_OUTPUT_RATE: prdata = 32'(out_rate_reg);
            dsfrs_pkg::REG_DAC_CLOCK:   prdata = 32'(dac_clock_reg);
            default:                    prdata = '0;
        endcase
    end

    // block state
    dsfrs_pkg::state_t state_reg, state_next;
    logic [AW-1:0]     wptr_reg;
    logic [PW-1:0]     pos_reg;
    logic [PENDW-1:0]  pend_reg;
    logic [dsfrs_pkg::STEP_W-1:0] step_reg;
    logic [PW-1:0]     step_mod_reg;
    logic [7:0]        cmd_reg;
    logic [7:0]        divisor_reg;
    logic              irq_flag_reg;
    logic              armed_reg;
    logic              new_xfer_reg;
    logic [7:0]        bias_reg;
    logic              irq_out_reg;
    logic [FCW-1:0]    cnt_reg;
    logic              from_mem_reg;
    logic [7:0]        res_rd_reg;
    logic              raised_reg;

    logic              m_valid_reg;
    logic [7:0]        m_rd_reg;
    logic [7:0]        m_smp_reg;
    logic              m_last_reg;
    logic              m_raise_reg;
    logic              m_level_reg;

    // status
    logic [63:0] pend64;
    logic        st_nearly;
    logic        st_empty;
    logic        st_full;
    logic        raise_cond;
    logic [7:0]  status_byte;
    logic [7:0]  rd_sel;
    logic        raise_now;

    always_comb begin
        pend64      = 64'(pend_reg);
        st_nearly   = (pend64 < NE_THR) && (cmd_reg[1:0] == 2'b11);
        st_empty    = (pend_reg == '0);
        st_full     = (pend64 > FULL_THR);
        raise_cond  = st_nearly && armed_reg;
        status_byte = {4'b0000, st_full, st_empty, st_nearly, irq_flag_reg};
        raise_now   = raise_cond && (s_req_type == dsfrs_pkg::REQ_FRAMES);
        case (s_req_type)
            dsfrs_pkg::REQ_CMD_RD:      rd_sel = cmd_reg;
            dsfrs_pkg::REQ_STATUS_RD:   rd_sel = status_byte;
            dsfrs_pkg::REQ_DIVISOR_RD:  rd_sel = divisor_reg;
            dsfrs_pkg::REQ_PRESENCE_RD: rd_sel = dsfrs_pkg::PRESENCE;
            default:                    rd_sel = '0;
        endcase
    end

    // handshake helpers
    logic clr_busy;
    logic accept;
    logic slot_free;

    assign s_ready   = (state_reg == dsfrs_pkg::S_IDLE) && !clr_busy;
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // store access
    logic [7:0]    bias_eff;
    logic          st_wr_en;
    logic [7:0]    st_wr_data;
    logic          st_rd_en;
    logic [7:0]    st_rd_data;
    logic          clr_start;

    always_comb begin
        bias_eff = bias_reg;
        if (new_xfer_reg && s_data_byte != 8'd0) begin
            bias_eff = s_data_byte - dsfrs_pkg::MIDLINE;
        end
        st_wr_en   = accept && (s_req_type == dsfrs_pkg::REQ_DATA_WR) && !st_full;
        st_wr_data = s_data_byte - bias_eff;
        st_rd_en   = (state_reg == dsfrs_pkg::S_FRAME_RD) && !st_empty;
        clr_start  = accept && (s_req_type == dsfrs_pkg::REQ_LEVEL_WR) &&
                     (s_data_byte == 8'd0);
    end

    dsfrs_store #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_start (clr_start),
        .wr_en     (st_wr_en),
        .wr_addr   (wptr_reg),
        .wr_data   (st_wr_data),
        .rd_en     (st_rd_en),
        .rd_addr   (pos_reg[PW-1:FRAC_BITS]),
        .rd_data   (st_rd_data),
        .clr_busy  (clr_busy)
    );

    // shared divider
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [DW-1:0]        div_divisor;
    logic [DW-1:0]        div_q;
    dsfrs_pkg::div_stat_t div_stat;
    logic [7:0]           d_eff;
    logic [dsfrs_pkg::STEP_W-1:0] step_sat;

    always_comb begin
        d_eff    = (s_data_byte < dsfrs_pkg::DIV_MIN) ? dsfrs_pkg::DIV_FALLBACK : s_data_byte;
        step_sat = (|div_q[DW-1:dsfrs_pkg::STEP_W]) ? dsfrs_pkg::STEP_MAX
                                                    : div_q[dsfrs_pkg::STEP_W-1:0];
        div_start    = 1'b0;
        div_dividend = DW'(dac_clock_reg);
        div_divisor  = DW'(d_eff);
        case (state_reg)
            dsfrs_pkg::S_IDLE: begin
                div_start = accept && (s_req_type == dsfrs_pkg::REQ_DIVISOR_WR);
            end
            dsfrs_pkg::S_DIV_CLOCK: begin
                // zero output rate needs no second pass
                div_start    = div_stat.done && (out_rate_reg != '0);
                div_dividend = DW'(div_q[dsfrs_pkg::CLOCK_W-1:0]) << FRAC_BITS;
                div_divisor  = DW'(out_rate_reg);
            end
            default: ;
        endcase
    end

    dsfrs_div #(
        .DW (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .stat      (div_stat)
    );

    // frame stepping
    logic [PW:0]      pos_sum;
    logic [PW-1:0]    pos_adv;
    logic [CMPW-1:0]  pend_w;
    logic [CMPW-1:0]  step_w;
    logic [PENDW-1:0] pend_dec;
    logic [PENDW:0]   pend_inc;
    logic [6:0]       fc_wide;
    logic [FCW-1:0]   fc_clamped;

    always_comb begin
        pos_sum  = {1'b0, pos_reg} + {1'b0, step_mod_reg};
        pos_adv  = (pos_sum >= (PW+1)'(SPAN)) ? PW'(pos_sum - (PW+1)'(SPAN)) : pos_sum[PW-1:0];
        pend_w   = CMPW'(pend_reg);
        step_w   = CMPW'(step_reg);
        pend_dec = (step_w >= pend_w) ? '0 : PENDW'(pend_w - step_w);
        pend_inc = {1'b0, pend_reg} + {1'b0, ONE_WORD};
        fc_wide  = {1'b0, s_frame_count};
        if (fc_wide == 7'd0) begin
            fc_wide = 7'd1;
        end else if (fc_wide > 7'(MAX_FRAMES)) begin
            fc_wide = 7'(MAX_FRAMES);
        end
        fc_clamped = FCW'(fc_wide);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dsfrs_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        dsfrs_pkg::REQ_DIVISOR_WR: state_next = dsfrs_pkg::S_DIV_CLOCK;
                        dsfrs_pkg::REQ_FRAMES:     state_next = dsfrs_pkg::S_FRAME_RD;
                        default:                   state_next = dsfrs_pkg::S_EMIT;
                    endcase
                end
            end
            dsfrs_pkg::S_DIV_CLOCK: begin
                if (div_stat.done) begin
                    state_next = (out_rate_reg == '0) ? dsfrs_pkg::S_DIV_SPAN
                                                      : dsfrs_pkg::S_DIV_RATE;
                end
            end
            dsfrs_pkg::S_DIV_RATE: begin
                if (div_stat.done) begin
                    state_next = dsfrs_pkg::S_DIV_SPAN;
                end
            end
            dsfrs_pkg::S_DIV_SPAN: begin
                state_next = dsfrs_pkg::S_EMIT;
            end
            dsfrs_pkg::S_FRAME_RD: begin
                state_next = dsfrs_pkg::S_FRAME_OUT;
            end
            dsfrs_pkg::S_FRAME_OUT: begin
                if (slot_free) begin
                    state_next = (cnt_reg == FCW'(1)) ? dsfrs_pkg::S_IDLE
                                                      : dsfrs_pkg::S_FRAME_RD;
                end
            end
            dsfrs_pkg::S_EMIT: begin
                if (slot_free) begin
                    state_next = dsfrs_pkg::S_IDLE;
                end
            end
            default: state_next = dsfrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dsfrs_pkg::S_IDLE;
            wptr_reg     <= '0;
            pos_reg      <= '0;
            pend_reg     <= '0;
            step_reg     <= '0;
            step_mod_reg <= '0;
            cmd_reg      <= '0;
            divisor_reg  <= '0;
            irq_flag_reg <= 1'b0;
            armed_reg    <= 1'b0;
            new_xfer_reg <= 1'b1;
            bias_reg     <= '0;
            irq_out_reg  <= 1'b0;
            cnt_reg      <= '0;
            raised_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                dsfrs_pkg::S_IDLE: begin
                    if (accept) begin
                        raised_reg <= raise_now;
                        res_rd_reg <= rd_sel;
                        case (s_req_type)
                            dsfrs_pkg::REQ_DATA_WR: begin
                                new_xfer_reg <= 1'b0;
                                bias_reg     <= bias_eff;
                                if (!st_full) begin
                                    wptr_reg <= (wptr_reg == AW'(FIFO_DEPTH - 1)) ? '0
                                                : wptr_reg + 1'b1;
                                    pend_reg <= (pend_inc > {1'b0, SPAN}) ? SPAN
                                                : pend_inc[PENDW-1:0];
                                end
                            end
                            dsfrs_pkg::REQ_CTRL_WR: begin
                                cmd_reg <= s_data_byte;
                                if (|s_data_byte[1:0]) begin
                                    armed_reg <= 1'b1;
                                end
                            end
                            dsfrs_pkg::REQ_DIVISOR_WR: begin
                                divisor_reg <= s_data_byte;
                            end
                            dsfrs_pkg::REQ_LEVEL_WR: begin
                                if (s_data_byte == 8'd0) begin
                                    irq_out_reg  <= 1'b0;
                                    wptr_reg     <= '0;
                                    pos_reg      <= '0;
                                    step_reg     <= '0;
                                    step_mod_reg <= '0;
                                    pend_reg     <= '0;
                                    armed_reg    <= 1'b0;
                                    new_xfer_reg <= 1'b1;
                                end
                            end
                            dsfrs_pkg::REQ_FRAMES: begin
                                cnt_reg <= fc_clamped;
                                if (raise_cond) begin
                                    irq_flag_reg <= 1'b1;
                                    armed_reg    <= 1'b0;
                                    irq_out_reg  <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // span is a power of two, so the step modulo span is its low bits
                dsfrs_pkg::S_DIV_CLOCK: begin
                    if (div_stat.done && out_rate_reg == '0) begin
                        step_reg     <= dsfrs_pkg::STEP_MAX;
                        step_mod_reg <= PW'(dsfrs_pkg::STEP_MAX);
                    end
                end
                dsfrs_pkg::S_DIV_RATE: begin
                    if (div_stat.done) begin
                        step_reg     <= step_sat;
                        step_mod_reg <= PW'(step_sat);
                    end
                end
                dsfrs_pkg::S_DIV_SPAN: begin
                    if (raise_cond) begin
                        irq_flag_reg <= 1'b1;
                        armed_reg    <= 1'b0;
                        irq_out_reg  <= 1'b1;
                        raised_reg   <= 1'b1;
                    end
                end
                dsfrs_pkg::S_FRAME_RD: begin
                    from_mem_reg <= st_rd_en;
                    if (st_rd_en) begin
                        pos_reg  <= pos_adv;
                        pend_reg <= pend_dec;
                    end
                end
                dsfrs_pkg::S_FRAME_OUT: begin
                    if (slot_free) begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_free && (state_reg == dsfrs_pkg::S_EMIT ||
                                   state_reg == dsfrs_pkg::S_FRAME_OUT)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && state_reg == dsfrs_pkg::S_EMIT) begin
            m_rd_reg    <= res_rd_reg;
            m_smp_reg   <= dsfrs_pkg::MIDLINE;
            m_last_reg  <= 1'b1;
            m_raise_reg <= raised_reg;
            m_level_reg <= irq_out_reg;
        end else if (slot_free && state_reg == dsfrs_pkg::S_FRAME_OUT) begin
            m_rd_reg    <= '0;
            m_smp_reg   <= from_mem_reg ? st_rd_data : dsfrs_pkg::MIDLINE;
            m_last_reg  <= (cnt_reg == FCW'(1));
            m_raise_reg <= raised_reg;
            m_level_reg <= irq_out_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_rd_reg;
    assign m_sample_out  = m_smp_reg;
    assign m_last_of_run = m_last_reg;
    assign m_irq_raise   = m_raise_reg;
    assign m_irq_level   = m_level_reg;

    // checks
    a_pend_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= SPAN)
        else $error("pending amount beyond span");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pos_reg} < (PW+1)'(SPAN))
        else $error("read position beyond span");

    a_no_take_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("request taken during memory sweep");

    a_frame_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsfrs_pkg::S_FRAME_RD || state_reg == dsfrs_pkg::S_FRAME_OUT)
        |-> cnt_reg != '0)
        else $error("frame counter ran out");

    a_div_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == dsfrs_pkg::S_DIV_CLOCK ||
                           state_reg == dsfrs_pkg::S_DIV_RATE))
        else $error("divider finished outside a divide step");

endmodule

`default_nettype wire

FILE: sv/dsfrs_div.sv
// ----------------------------------------------------------------------------
// dsfrs_div: shared restoring divider
// One quotient bit per cycle; done is raised together with the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfrs_div #(
    parameter int DW = 40
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [DW-1:0]       dividend,
    input  wire logic [DW-1:0]       divisor,
    output logic [DW-1:0]            quotient,
    output dsfrs_pkg::div_stat_t     stat
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quot_reg;
    logic [DW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    always_comb begin
        rem_sh  = {rem_reg, quot_reg[DW-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quot_reg <= {quot_reg[DW-2:0], ge};
        end
    end

    assign quotient  = quot_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

FILE: sv/dsfrs_store.sv
// ----------------------------------------------------------------------------
// dsfrs_store: sample memory
// One write and one registered read port; a clearing sweep fills midline.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfrs_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clr_start,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data,
    output logic               clr_busy
);

    logic [7:0]    mem [DEPTH];
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    always_comb begin
        we    = clr_reg | wr_en;
        waddr = clr_reg ? clr_cnt_reg : wr_addr;
        wdata = clr_reg ? dsfrs_pkg::MIDLINE : wr_data;
    end

    // sweep runs once after reset and again on each clear request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_start) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clr_busy = clr_reg;

endmodule

`default_nettype wire
